@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the circle point generator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CPG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define CPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/cpg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpg_pkg
// Widths and limits shared by the circle point generator modules.
// ----------------------------------------------------------------------------
package cpg_pkg;

   localparam int RAD_BITS   = 5;   // radius and offset fields
   localparam int PT_BITS    = 13;  // mirrored point fields
   localparam int X_BITS     = 6;   // step x register
   localparam int Y_BITS     = 7;   // step y register, signed
   localparam int DEC_BITS   = 9;   // decision register, signed
   localparam int CALC_BITS  = 12;  // decision arithmetic
   localparam int CNT_BITS   = 6;   // results per request
   localparam int MAX_OUT    = 63;
   localparam int QDEPTH     = 2;
   localparam int QPTR_BITS  = 1;
   localparam int QCNT_BITS  = 2;

endpackage

@@ rtl/cpg_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpg_front
// Request intake: radius saturation and a two-entry queue to the stepper.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpg_front
   import cpg_pkg::*;
#(
   parameter int MAX_RADIUS = 31,
   parameter int COORD_BITS = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_BITS-1:0] req_center_x,
   input  logic [COORD_BITS-1:0] req_center_y,
   input  logic [RAD_BITS-1:0]   req_radius,
   output logic                  job_valid,
   input  logic                  job_pop,
   output logic [COORD_BITS-1:0] job_center_x,
   output logic [COORD_BITS-1:0] job_center_y,
   output logic [RAD_BITS-1:0]   job_radius
);

   logic [COORD_BITS-1:0] q_cx_ff [QDEPTH];
   logic [COORD_BITS-1:0] q_cy_ff [QDEPTH];
   logic [RAD_BITS-1:0]   q_r_ff  [QDEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  push;
   logic [RAD_BITS-1:0]   radius_sat;

   assign req_stall = (count_ff == QCNT_BITS'(QDEPTH));
   assign push      = req_valid && !req_stall;

   // radius above the bound is clamped
   assign radius_sat = ({1'b0, req_radius} > (RAD_BITS+1)'(MAX_RADIUS)) ?
                       RAD_BITS'(MAX_RADIUS) : req_radius;

   assign job_valid    = (count_ff != '0);
   assign job_center_x = q_cx_ff[rd_ptr_ff];
   assign job_center_y = q_cy_ff[rd_ptr_ff];
   assign job_radius   = q_r_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = job_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !job_pop) begin
         count_in = count_ff + 1'b1;
      end else if (job_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_cx_ff[wr_ptr_ff] <= req_center_x;
         q_cy_ff[wr_ptr_ff] <= req_center_y;
         q_r_ff[wr_ptr_ff]  <= radius_sat;
      end
   end

   `CPG_ASSERT(a_queue_bound, clock, reset, count_ff <= QCNT_BITS'(QDEPTH), "queue overfilled")
   `CPG_ASSERT(a_pop_nonempty, clock, reset, !job_pop || job_valid, "pop from empty queue")

endmodule

@@ rtl/cpg_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpg_back
// Midpoint stepper: one step per cycle, unless a stalled result is held, into a registered result stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpg_back
   import cpg_pkg::*;
#(
   parameter int COORD_BITS = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   output logic                       job_pop,
   input  logic [COORD_BITS-1:0]      job_center_x,
   input  logic [COORD_BITS-1:0]      job_center_y,
   input  logic [RAD_BITS-1:0]        job_radius,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [RAD_BITS-1:0]        rsp_offset_x,
   output logic [RAD_BITS-1:0]        rsp_offset_y,
   output logic signed [PT_BITS-1:0]  rsp_point_a_x,
   output logic signed [PT_BITS-1:0]  rsp_point_a_y,
   output logic signed [PT_BITS-1:0]  rsp_point_b_x,
   output logic signed [PT_BITS-1:0]  rsp_point_b_y,
   output logic signed [PT_BITS-1:0]  rsp_point_c_x,
   output logic signed [PT_BITS-1:0]  rsp_point_c_y,
   output logic signed [PT_BITS-1:0]  rsp_point_d_x,
   output logic signed [PT_BITS-1:0]  rsp_point_d_y,
   output logic                       rsp_last_step
);

   localparam int SW = COORD_BITS + 8;

   logic                        busy_ff, busy_in;
   logic [X_BITS-1:0]           x_ff;
   logic signed [Y_BITS-1:0]    y_ff;
   logic signed [DEC_BITS-1:0]  d_ff;
   logic [COORD_BITS-1:0]       cx_ff, cy_ff;
   logic [CNT_BITS-1:0]         count_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        step;

   logic signed [CALC_BITS-1:0] xe, ye, de, x1, y1, err;
   logic signed [CALC_BITS-1:0] x_n, y_n, d_n;
   logic                        last;

   logic signed [SW-1:0]        cxe, cye, xo, yo;
   logic signed [SW-1:0]        sum_xp, sum_xm, sum_yp, sum_ym;

   logic [RAD_BITS-1:0]         offset_x_ff, offset_y_ff;
   logic signed [PT_BITS-1:0]   xp_ff, xm_ff, yp_ff, ym_ff;
   logic                        last_ff;

   assign job_pop = !busy_ff && job_valid;
   assign step    = busy_ff && (!rsp_valid_ff || !rsp_stall);

   // decision update
   always_comb begin
      xe  = signed'({{(CALC_BITS-X_BITS){1'b0}}, x_ff});
      ye  = {{(CALC_BITS-Y_BITS){y_ff[Y_BITS-1]}}, y_ff};
      de  = {{(CALC_BITS-DEC_BITS){d_ff[DEC_BITS-1]}}, d_ff};
      x1  = xe + CALC_BITS'(1);
      y1  = ye - CALC_BITS'(1);
      err = ((de + ye) <<< 1) - CALC_BITS'(1);
      priority if (de < 0 && err <= 0) begin
         x_n = x1;
         y_n = ye;
         d_n = de + (x1 <<< 1) + CALC_BITS'(1);
      end else if (de > 0 && err > 0) begin
         x_n = xe;
         y_n = y1;
         d_n = de - ((y1 <<< 1) + CALC_BITS'(1));
      end else begin
         // diagonal move
         x_n = x1;
         y_n = y1;
         d_n = de + ((x1 - y1) <<< 1);
      end
      last = (y_n < 0) || (count_ff == CNT_BITS'(MAX_OUT - 1));
   end

   // mirrored points, wrapped to the field width
   always_comb begin
      cxe    = signed'({{(SW-COORD_BITS){1'b0}}, cx_ff});
      cye    = signed'({{(SW-COORD_BITS){1'b0}}, cy_ff});
      xo     = signed'({{(SW-X_BITS){1'b0}}, x_ff});
      yo     = {{(SW-Y_BITS){y_ff[Y_BITS-1]}}, y_ff};
      sum_xp = cxe + xo;
      sum_xm = cxe - xo;
      sum_yp = cye + yo;
      sum_ym = cye - yo;
   end

   always_comb begin
      busy_in = busy_ff;
      if (job_pop) begin
         busy_in = 1'b1;
      end else if (step && last) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         cx_ff    <= job_center_x;
         cy_ff    <= job_center_y;
         x_ff     <= '0;
         y_ff     <= signed'({{(Y_BITS-RAD_BITS){1'b0}}, job_radius});
         d_ff     <= DEC_BITS'(1) - signed'({{(DEC_BITS-RAD_BITS-1){1'b0}}, job_radius, 1'b0});
         count_ff <= '0;
      end else if (step) begin
         x_ff     <= x_n[X_BITS-1:0];
         y_ff     <= y_n[Y_BITS-1:0];
         d_ff     <= d_n[DEC_BITS-1:0];
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         offset_x_ff <= x_ff[RAD_BITS-1:0];
         offset_y_ff <= y_ff[RAD_BITS-1:0];
         xp_ff       <= sum_xp[PT_BITS-1:0];
         xm_ff       <= sum_xm[PT_BITS-1:0];
         yp_ff       <= sum_yp[PT_BITS-1:0];
         ym_ff       <= sum_ym[PT_BITS-1:0];
         last_ff     <= last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_offset_x  = offset_x_ff;
   assign rsp_offset_y  = offset_y_ff;
   assign rsp_point_a_x = xp_ff;
   assign rsp_point_a_y = yp_ff;
   assign rsp_point_b_x = xp_ff;
   assign rsp_point_b_y = ym_ff;
   assign rsp_point_c_x = xm_ff;
   assign rsp_point_c_y = yp_ff;
   assign rsp_point_d_x = xm_ff;
   assign rsp_point_d_y = ym_ff;
   assign rsp_last_step = last_ff;

   `CPG_ASSERT(a_busy_y_nonneg, clock, reset, !busy_ff || !y_ff[Y_BITS-1], "walk below axis")
   `CPG_ASSERT(a_busy_count, clock, reset, !busy_ff || count_ff < CNT_BITS'(MAX_OUT), "too many steps")
   `CPG_ASSERT_NEXT(a_last_idle, clock, reset, step && last, !busy_ff && rsp_valid_ff && rsp_last_step, "final step not closed")
   `CPG_ASSERT_NEXT(a_pop_busy, clock, reset, job_pop, busy_ff && count_ff == '0, "job load lost")

endmodule

@@ rtl/circle_point_generator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_point_generator_core
// Midpoint circle walker giving four mirrored points per step.
// ----------------------------------------------------------------------------
// A request (center, radius R, clamped to MAX_RADIUS) yields between 1 and
// 2R+1 responses, one per clock while rsp_stall is low, the last one flagged
// by rsp_last_step. The stepper loads each request from a two-entry queue
// while idle, before its first step; each step is one pass of the single
// decision update in the stepper. Up to two requests are held while the
// stepper is busy; the response register lets the walk run ahead of a
// stalled consumer by one result.

module circle_point_generator_core
   import cpg_pkg::*;
#(
   parameter int MAX_RADIUS = 31,
   parameter int COORD_BITS = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [COORD_BITS-1:0]      req_center_x,
   input  logic [COORD_BITS-1:0]      req_center_y,
   input  logic [RAD_BITS-1:0]        req_radius,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [RAD_BITS-1:0]        rsp_offset_x,
   output logic [RAD_BITS-1:0]        rsp_offset_y,
   output logic signed [PT_BITS-1:0]  rsp_point_a_x,
   output logic signed [PT_BITS-1:0]  rsp_point_a_y,
   output logic signed [PT_BITS-1:0]  rsp_point_b_x,
   output logic signed [PT_BITS-1:0]  rsp_point_b_y,
   output logic signed [PT_BITS-1:0]  rsp_point_c_x,
   output logic signed [PT_BITS-1:0]  rsp_point_c_y,
   output logic signed [PT_BITS-1:0]  rsp_point_d_x,
   output logic signed [PT_BITS-1:0]  rsp_point_d_y,
   output logic                       rsp_last_step
);

   logic                  job_valid;
   logic                  job_pop;
   logic [COORD_BITS-1:0] job_center_x;
   logic [COORD_BITS-1:0] job_center_y;
   logic [RAD_BITS-1:0]   job_radius;

   cpg_front #(
      .MAX_RADIUS (MAX_RADIUS),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .job_valid    (job_valid),
      .job_pop      (job_pop),
      .job_center_x (job_center_x),
      .job_center_y (job_center_y),
      .job_radius   (job_radius)
   );

   cpg_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job_pop       (job_pop),
      .job_center_x  (job_center_x),
      .job_center_y  (job_center_y),
      .job_radius    (job_radius),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_offset_x  (rsp_offset_x),
      .rsp_offset_y  (rsp_offset_y),
      .rsp_point_a_x (rsp_point_a_x),
      .rsp_point_a_y (rsp_point_a_y),
      .rsp_point_b_x (rsp_point_b_x),
      .rsp_point_b_y (rsp_point_b_y),
      .rsp_point_c_x (rsp_point_c_x),
      .rsp_point_c_y (rsp_point_c_y),
      .rsp_point_d_x (rsp_point_d_x),
      .rsp_point_d_y (rsp_point_d_y),
      .rsp_last_step (rsp_last_step)
   );

endmodule
